>>> sv/mss_pkg.sv
// ----------------------------------------------------------------------------
// mss_pkg
// shared types and constants of the shaker-sort median block
// ----------------------------------------------------------------------------
`default_nettype none

package mss_pkg;

  // fixed field widths
  localparam int unsigned SampleW = 8;
  localparam int unsigned MedianW = 9;
  localparam int unsigned SizeW   = 7;

  // default store depth
  localparam int unsigned DepthDefault = 32;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_RD,
    ST_CMP,
    ST_WR,
    ST_MED_RD,
    ST_MED_CAP
  } mss_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;     // store the incoming sample
    logic rd_en;    // read both addressed entries
    logic wr_lo;    // write upper read value to lower address
    logic wr_hi;    // write lower read value to upper address
    logic capture;  // load the result register
  } mss_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic gt;        // lower entry is greater than upper entry
    logic out_free;  // result register can take a new result
  } mss_sts_t;

endpackage

`default_nettype wire

>>> sv/mss_if.sv
// ----------------------------------------------------------------------------
// mss_in_if / mss_out_if
// valid/ready channels for samples and results
// ----------------------------------------------------------------------------
`default_nettype none

interface mss_in_if;
  import mss_pkg::*;

  logic               valid;
  logic               ready;
  logic [SampleW-1:0] value;
  logic               is_final;

  modport source (output valid, value, is_final, input ready);
  modport sink   (input valid, value, is_final, output ready);
endinterface

interface mss_out_if;
  import mss_pkg::*;

  logic               valid;
  logic               ready;
  logic [MedianW-1:0] median_doubled;
  logic [SizeW-1:0]   set_size;
  logic               empty_set;
  logic               overflowed;

  modport source (output valid, median_doubled, set_size, empty_set, overflowed, input ready);
  modport sink   (input valid, median_doubled, set_size, empty_set, overflowed, output ready);
endinterface

`default_nettype wire

>>> sv/mss_ctrl.sv
// ----------------------------------------------------------------------------
// mss_ctrl
// sequencer for loading, shaker-sort passes and median readout
// ----------------------------------------------------------------------------
`default_nettype none

module mss_ctrl #(
  parameter int unsigned AddrW  = 5,
  parameter int unsigned CountW = 6
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_final_i,
  output      logic               in_ready_o,
  input  wire logic [CountW-1:0]  fill_i,
  input  wire mss_pkg::mss_sts_t  sts_i,
  output      mss_pkg::mss_cmd_t  cmd_o,
  output      logic [AddrW-1:0]   addr_a_o,
  output      logic [AddrW-1:0]   addr_b_o
);
  import mss_pkg::*;

  mss_state_e       state_q, state_d;
  logic [AddrW-1:0] left_q, left_d;
  logic [AddrW-1:0] right_q, right_d;
  logic [AddrW-1:0] pos_q, pos_d;
  logic             fwd_q, fwd_d;
  logic             swapped_q, swapped_d;

  logic [AddrW-1:0]  pos_inc;
  logic [AddrW-1:0]  right_dec;
  logic [AddrW-1:0]  left_inc;
  logic [CountW-1:0] mid;
  logic [CountW-1:0] mid_dec;
  logic              step_done;

  assign pos_inc   = pos_q + 1'b1;
  assign right_dec = right_q - 1'b1;
  assign left_inc  = left_q + 1'b1;
  assign mid       = fill_i >> 1;
  assign mid_dec   = mid - 1'b1;

  // next state and loop bounds
  always_comb begin
    state_d   = state_q;
    left_d    = left_q;
    right_d   = right_q;
    pos_d     = pos_q;
    fwd_d     = fwd_q;
    swapped_d = swapped_q;
    step_done = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_final_i) state_d = ST_START;
      end
      ST_START: begin
        if ((fill_i >> 1) == '0) begin
          state_d = ST_MED_RD;
        end else begin
          left_d    = '0;
          right_d   = AddrW'(fill_i - 1'b1);
          pos_d     = '0;
          fwd_d     = 1'b1;
          swapped_d = 1'b0;
          state_d   = ST_RD;
        end
      end
      ST_RD: state_d = ST_CMP;
      ST_CMP: begin
        if (sts_i.gt) begin
          swapped_d = 1'b1;
          state_d   = ST_WR;
        end else begin
          step_done = 1'b1;
        end
      end
      ST_WR:     step_done = 1'b1;
      ST_MED_RD: state_d = ST_MED_CAP;
      ST_MED_CAP: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    if (step_done) begin
      state_d = ST_RD;
      if (fwd_q) begin
        if (pos_inc != right_q) begin
          pos_d = pos_inc;
        end else begin
          // forward pass done, shrink right bound
          right_d = right_dec;
          if (right_dec > left_q) begin
            fwd_d = 1'b0;
            pos_d = right_dec - 1'b1;
          end else if (swapped_d && (left_inc < right_dec)) begin
            left_d    = left_inc;
            pos_d     = left_inc;
            swapped_d = 1'b0;
          end else begin
            state_d = ST_MED_RD;
          end
        end
      end else begin
        if (pos_q != left_q) begin
          pos_d = pos_q - 1'b1;
        end else if (swapped_d && (left_inc < right_q)) begin
          // backward pass done, new round
          left_d    = left_inc;
          pos_d     = left_inc;
          fwd_d     = 1'b1;
          swapped_d = 1'b0;
        end else begin
          state_d = ST_MED_RD;
        end
      end
    end
  end

  // command outputs
  always_comb begin
    in_ready_o    = (state_q == ST_IDLE);
    cmd_o.load    = in_valid_i && (state_q == ST_IDLE);
    cmd_o.rd_en   = (state_q == ST_RD) || (state_q == ST_MED_RD);
    cmd_o.wr_lo   = (state_q == ST_CMP) && sts_i.gt;
    cmd_o.wr_hi   = (state_q == ST_WR);
    cmd_o.capture = (state_q == ST_MED_CAP) && sts_i.out_free;
    if ((state_q == ST_MED_RD) || (state_q == ST_MED_CAP)) begin
      addr_a_o = fill_i[0] ? mid[AddrW-1:0] : mid_dec[AddrW-1:0];
      addr_b_o = mid[AddrW-1:0];
    end else begin
      addr_a_o = pos_q;
      addr_b_o = pos_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      left_q    <= '0;
      right_q   <= '0;
      pos_q     <= '0;
      fwd_q     <= 1'b1;
      swapped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      left_q    <= left_d;
      right_q   <= right_d;
      pos_q     <= pos_d;
      fwd_q     <= fwd_d;
      swapped_q <= swapped_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/mss_dpath.sv
// ----------------------------------------------------------------------------
// mss_dpath
// sample store, compare/swap path, fill tracking and result register
// ----------------------------------------------------------------------------
`default_nettype none

module mss_dpath #(
  parameter int unsigned Depth  = 32,
  parameter int unsigned AddrW  = 5,
  parameter int unsigned CountW = 6
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire mss_pkg::mss_cmd_t           cmd_i,
  input  wire logic [AddrW-1:0]            addr_a_i,
  input  wire logic [AddrW-1:0]            addr_b_i,
  input  wire logic [mss_pkg::SampleW-1:0] value_i,
  output      mss_pkg::mss_sts_t           sts_o,
  output      logic [CountW-1:0]           fill_o,
  output      logic                        out_valid_o,
  input  wire logic                        out_ready_i,
  output      logic [mss_pkg::MedianW-1:0] median_doubled_o,
  output      logic [mss_pkg::SizeW-1:0]   set_size_o,
  output      logic                        empty_set_o,
  output      logic                        overflowed_o
);
  import mss_pkg::*;

  logic [SampleW-1:0] mem [Depth];
  logic [SampleW-1:0] rd_a_q, rd_b_q;
  logic [CountW-1:0]  fill_q;
  logic               drop_q;
  logic               full;
  logic               out_valid_q;
  logic [MedianW-1:0] med_q;
  logic [SizeW-1:0]   size_q;
  logic               empty_q;
  logic               ovf_q;
  logic [MedianW-1:0] pair_sum;

  assign full     = (fill_q == CountW'(Depth));
  assign pair_sum = {1'b0, rd_a_q} + {1'b0, rd_b_q};

  // single write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) begin
      mem[fill_q[AddrW-1:0]] <= value_i;
    end else if (cmd_i.wr_lo) begin
      mem[addr_a_i] <= rd_b_q;
    end else if (cmd_i.wr_hi) begin
      mem[addr_b_i] <= rd_a_q;
    end
    if (cmd_i.rd_en) begin
      rd_a_q <= mem[addr_a_i];
      rd_b_q <= mem[addr_b_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      drop_q <= 1'b0;
    end else if (cmd_i.capture) begin
      fill_q <= '0;
      drop_q <= 1'b0;
    end else if (cmd_i.load) begin
      if (full) drop_q <= 1'b1;
      else      fill_q <= fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.capture) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      med_q   <= (fill_q == '0) ? '0 : pair_sum;
      size_q  <= SizeW'(fill_q);
      empty_q <= (fill_q == '0);
      ovf_q   <= drop_q;
    end
  end

  assign sts_o.gt       = (rd_a_q > rd_b_q);
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign fill_o         = fill_q;

  assign out_valid_o      = out_valid_q;
  assign median_doubled_o = med_q;
  assign set_size_o       = size_q;
  assign empty_set_o      = empty_q;
  assign overflowed_o     = ovf_q;

endmodule

`default_nettype wire

>>> sv/median_by_shaker_sort_core.sv
// ----------------------------------------------------------------------------
// median_by_shaker_sort_core
// median of a set of 8-bit samples via in-place cocktail shaker sort
// ----------------------------------------------------------------------------
// loading: one sample per cycle while idle, no result for non-final samples
// final sample: starts the sort; each compare reads a pair (ST_RD), compares
//   it (ST_CMP); a swap writes it back in ST_CMP, ST_WR (one-write/two-read)
// median readout: ST_MED_RD, then ST_MED_CAP loads the free result register
// reset: clears controller, fill count and drop flag; store is not cleared
`default_nettype none

module median_by_shaker_sort_core #(
  parameter int unsigned DEPTH = mss_pkg::DepthDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mss_in_if.sink    in_i,
  mss_out_if.source out_o
);
  import mss_pkg::*;

  // store index and fill count widths
  localparam int unsigned AddrW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CountW = $clog2(DEPTH + 1);

  mss_cmd_t          cmd;
  mss_sts_t          sts;
  logic [AddrW-1:0]  addr_a;
  logic [AddrW-1:0]  addr_b;
  logic [CountW-1:0] fill;

  // sequencer: accepts requests while idle, then runs the sort passes
  mss_ctrl #(
    .AddrW  (AddrW),
    .CountW (CountW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_final_i (in_i.is_final),
    .in_ready_o (in_i.ready),
    .fill_i     (fill),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .addr_a_o   (addr_a),
    .addr_b_o   (addr_b)
  );

  // store, comparator, pair adder and result register
  mss_dpath #(
    .Depth  (DEPTH),
    .AddrW  (AddrW),
    .CountW (CountW)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .addr_a_i         (addr_a),
    .addr_b_i         (addr_b),
    .value_i          (in_i.value),
    .sts_o            (sts),
    .fill_o           (fill),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .median_doubled_o (out_o.median_doubled),
    .set_size_o       (out_o.set_size),
    .empty_set_o      (out_o.empty_set),
    .overflowed_o     (out_o.overflowed)
  );

`ifndef SYNTHESIS
  // fill count never passes capacity
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill <= CountW'(DEPTH))
    else $error("fill count beyond capacity");

  // second half of a swap always follows the first half
  a_swap_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_hi |-> $past(cmd.wr_lo))
    else $error("upper swap write without lower write");

  // a result appears only after a capture
  a_out_from_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(cmd.capture))
    else $error("result valid without capture");

  // capture never overwrites a pending result
  a_capture_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |-> (!out_o.valid || out_o.ready))
    else $error("capture over pending result");
`endif

endmodule

`default_nettype wire
